// File: hdl/ggem_pkg.sv
package ggem_pkg;

    localparam int MAX_ROWS = 256;
    localparam int MAX_COLS = 256;

    localparam int ROW_AW      = $clog2(MAX_ROWS);
    localparam int COL_AW      = $clog2(MAX_COLS);
    localparam int FRAME_AW    = ROW_AW + COL_AW;
    localparam int FRAME_DEPTH = MAX_ROWS * (2 ** COL_AW);

    localparam int DIM_MAX = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int COORD_W = $clog2(DIM_MAX + 1024) + 1;

    localparam int PIX_W      = 8;
    localparam int KIND_W     = 2;
    localparam int ADDR_IN_W  = 8;
    localparam int STEP_W     = 8;
    localparam int SIZE_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [PIX_W-1:0] MARK_CHAN1 = 8'd125;
    localparam logic [PIX_W-1:0] MARK_CHAN2 = 8'd254;
    localparam int MARK_WIDTH = 5;

    localparam logic [PIX_W-1:0]  THRESH_RESET = 8'd20;
    localparam logic [STEP_W-1:0] STEP_RESET   = 8'd4;
    localparam logic [SIZE_W-1:0] SIZE_RESET   = 9'd256;

    typedef logic [COORD_W-1:0] t_coord;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_RUN   = 2'd1,
        KIND_READ  = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESH = 2'd0,
        CFG_STEP   = 2'd1,
        CFG_ROWS   = 2'd2,
        CFG_COLS   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_RUN_P0,
        ST_SAMPLE,
        ST_COMPARE,
        ST_SETUP,
        ST_PAINT,
        ST_DONE
    } t_state;

    function automatic logic [PIX_W-1:0] f_absdiff(input logic [PIX_W-1:0] a,
                                                   input logic [PIX_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic t_coord f_min(input t_coord a, input t_coord b);
        return (a < b) ? a : b;
    endfunction

endpackage

// File: hdl/ggem_in_if.sv
interface ggem_in_if;
    logic                             valid;
    logic                             ready;
    logic [ggem_pkg::KIND_W-1:0]      kind;
    logic [ggem_pkg::ADDR_IN_W-1:0]   row;
    logic [ggem_pkg::ADDR_IN_W-1:0]   col;
    logic [ggem_pkg::PIX_W-1:0]       in_chan0;
    logic [ggem_pkg::PIX_W-1:0]       in_chan1;
    logic [ggem_pkg::PIX_W-1:0]       in_chan2;

    modport source (output valid, kind, row, col, in_chan0, in_chan1, in_chan2,
                    input ready);
    modport sink (input valid, kind, row, col, in_chan0, in_chan1, in_chan2,
                  output ready);
endinterface

// File: hdl/ggem_out_if.sv
interface ggem_out_if;
    logic                       valid;
    logic                       ready;
    logic [ggem_pkg::PIX_W-1:0] out_chan0;
    logic [ggem_pkg::PIX_W-1:0] out_chan1;
    logic [ggem_pkg::PIX_W-1:0] out_chan2;

    modport source (output valid, out_chan0, out_chan1, out_chan2, input ready);
    modport sink (input valid, out_chan0, out_chan1, out_chan2, output ready);
endinterface

// File: hdl/ggem_ram.sv
module ggem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/grid_gradient_edge_marker.sv
// Grid gradient edge marker. Pixel writes and pixel reads go through the frame
// memories, one item at a time; every item gives one result, zeros except for a
// read. A run item walks the sample grid: each sample passes through memory
// read, compare and decision, then paints the pixels of each mark in turn, up
// to 5*step pixels for each of its two possible marks, and returns to the
// decision after each mark.
// Channel 0 and channels 1/2 live in separate memories, so marks are plain
// writes; the column history is a small memory read one sample row later.
module grid_gradient_edge_marker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ggem_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ggem_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    ggem_in_if.sink                          i_in,
    ggem_out_if.source                       o_out
);

    localparam int PW = ggem_pkg::PIX_W;

    ggem_pkg::t_state r_state, n_state;

    logic [PW-1:0]                     r_thr;
    logic [ggem_pkg::STEP_W-1:0]       r_step;
    logic [ggem_pkg::SIZE_W-1:0]       r_rows_cfg;
    logic [ggem_pkg::SIZE_W-1:0]       r_cols_cfg;

    ggem_pkg::t_coord r_i, n_i, r_j, n_j;
    ggem_pkg::t_coord r_r, n_r, r_c, n_c, r_c0, n_c0, r_r_end, n_r_end, r_c_end, n_c_end;
    logic [PW-1:0]    r_scan_prev, n_scan_prev, r_p0, n_p0;
    logic             r_hit_scan, n_hit_scan, r_hit_col, n_hit_col;
    logic             r_rd_inside, n_rd_inside;

    logic             r_out_valid, n_out_valid;
    logic [PW-1:0]    r_out_c0, n_out_c0, r_out_c1, n_out_c1, r_out_c2, n_out_c2;

    ggem_pkg::t_coord w_rows, w_cols, w_step, w_in_row, w_in_col;
    ggem_pkg::t_coord w_j_next, w_i_next;
    logic             w_accept, w_inside;
    logic [PW-1:0]    w_colp;

    logic                             w_c0_we, w_c12_we, w_col_we;
    logic [ggem_pkg::FRAME_AW-1:0]    w_c0_waddr, w_c0_raddr, w_c12_waddr, w_c12_raddr;
    logic [PW-1:0]                    w_c0_wdata, w_c0_rdata;
    logic [2*PW-1:0]                  w_c12_wdata, w_c12_rdata;
    logic [ggem_pkg::COL_AW-1:0]      w_col_addr;
    logic [PW-1:0]                    w_col_rdata;

    assign w_rows = (ggem_pkg::t_coord'(r_rows_cfg) > ggem_pkg::t_coord'(ggem_pkg::MAX_ROWS))
                  ? ggem_pkg::t_coord'(ggem_pkg::MAX_ROWS) : ggem_pkg::t_coord'(r_rows_cfg);
    assign w_cols = (ggem_pkg::t_coord'(r_cols_cfg) > ggem_pkg::t_coord'(ggem_pkg::MAX_COLS))
                  ? ggem_pkg::t_coord'(ggem_pkg::MAX_COLS) : ggem_pkg::t_coord'(r_cols_cfg);
    assign w_step   = ggem_pkg::t_coord'(r_step);
    assign w_in_row = ggem_pkg::t_coord'(i_in.row);
    assign w_in_col = ggem_pkg::t_coord'(i_in.col);
    assign w_inside = (w_in_row < ggem_pkg::t_coord'(ggem_pkg::MAX_ROWS))
                   && (w_in_col < ggem_pkg::t_coord'(ggem_pkg::MAX_COLS));
    assign w_j_next = ggem_pkg::t_coord'(r_j + w_step);
    assign w_i_next = ggem_pkg::t_coord'(r_i + w_step);
    assign w_colp   = (r_i == w_step) ? r_p0 : w_col_rdata;

    assign i_in.ready      = i_rst_n && (r_state == ggem_pkg::ST_IDLE)
                          && (!r_out_valid || o_out.ready);
    assign w_accept        = i_in.valid && i_in.ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.out_chan0 = r_out_c0;
    assign o_out.out_chan1 = r_out_c1;
    assign o_out.out_chan2 = r_out_c2;

    // memory ports
    always_comb begin
        w_c0_we     = 1'b0;
        w_c0_waddr  = {w_in_row[ggem_pkg::ROW_AW-1:0], w_in_col[ggem_pkg::COL_AW-1:0]};
        w_c0_wdata  = i_in.in_chan0;
        w_c0_raddr  = {w_in_row[ggem_pkg::ROW_AW-1:0], w_in_col[ggem_pkg::COL_AW-1:0]};
        w_c12_we    = 1'b0;
        w_c12_waddr = {w_in_row[ggem_pkg::ROW_AW-1:0], w_in_col[ggem_pkg::COL_AW-1:0]};
        w_c12_wdata = {i_in.in_chan2, i_in.in_chan1};
        w_c12_raddr = {w_in_row[ggem_pkg::ROW_AW-1:0], w_in_col[ggem_pkg::COL_AW-1:0]};
        w_col_we    = 1'b0;
        w_col_addr  = r_j[ggem_pkg::COL_AW-1:0];

        if (r_state == ggem_pkg::ST_IDLE) begin
            if (w_accept && i_in.kind == ggem_pkg::KIND_WRITE && w_inside) begin
                w_c0_we  = 1'b1;
                w_c12_we = 1'b1;
            end
            if (i_in.kind == ggem_pkg::KIND_RUN) begin
                w_c0_raddr = '0;
            end
        end else if (r_state == ggem_pkg::ST_SAMPLE) begin
            w_c0_raddr = {r_i[ggem_pkg::ROW_AW-1:0], r_j[ggem_pkg::COL_AW-1:0]};
        end else if (r_state == ggem_pkg::ST_COMPARE) begin
            w_col_we = 1'b1;
        end else if (r_state == ggem_pkg::ST_PAINT) begin
            w_c12_we    = 1'b1;
            w_c12_waddr = {r_r[ggem_pkg::ROW_AW-1:0], r_c[ggem_pkg::COL_AW-1:0]};
            w_c12_wdata = {ggem_pkg::MARK_CHAN2, ggem_pkg::MARK_CHAN1};
        end
    end

    ggem_ram #(.WIDTH(PW), .DEPTH(ggem_pkg::FRAME_DEPTH)) u_chan0_ram (
        .i_clk   (i_clk),
        .i_we    (w_c0_we),
        .i_waddr (w_c0_waddr),
        .i_wdata (w_c0_wdata),
        .i_raddr (w_c0_raddr),
        .o_rdata (w_c0_rdata)
    );

    ggem_ram #(.WIDTH(2 * PW), .DEPTH(ggem_pkg::FRAME_DEPTH)) u_chan12_ram (
        .i_clk   (i_clk),
        .i_we    (w_c12_we),
        .i_waddr (w_c12_waddr),
        .i_wdata (w_c12_wdata),
        .i_raddr (w_c12_raddr),
        .o_rdata (w_c12_rdata)
    );

    ggem_ram #(.WIDTH(PW), .DEPTH(ggem_pkg::MAX_COLS)) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (w_col_we),
        .i_waddr (w_col_addr),
        .i_wdata (w_c0_rdata),
        .i_raddr (w_col_addr),
        .o_rdata (w_col_rdata)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_r         = r_r;
        n_c         = r_c;
        n_c0        = r_c0;
        n_r_end     = r_r_end;
        n_c_end     = r_c_end;
        n_scan_prev = r_scan_prev;
        n_p0        = r_p0;
        n_hit_scan  = r_hit_scan;
        n_hit_col   = r_hit_col;
        n_rd_inside = r_rd_inside;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_c0    = r_out_c0;
        n_out_c1    = r_out_c1;
        n_out_c2    = r_out_c2;

        unique case (r_state)
            ggem_pkg::ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_in.kind)
                        ggem_pkg::KIND_READ: begin
                            n_rd_inside = w_inside;
                            n_state     = ggem_pkg::ST_READ;
                        end
                        ggem_pkg::KIND_RUN: begin
                            n_state = ggem_pkg::ST_RUN_P0;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out_c0    = '0;
                            n_out_c1    = '0;
                            n_out_c2    = '0;
                        end
                    endcase
                end
            end
            ggem_pkg::ST_READ: begin
                n_out_valid = 1'b1;
                n_out_c0    = r_rd_inside ? w_c0_rdata : '0;
                n_out_c1    = r_rd_inside ? w_c12_rdata[PW-1:0] : '0;
                n_out_c2    = r_rd_inside ? w_c12_rdata[2*PW-1:PW] : '0;
                n_state     = ggem_pkg::ST_IDLE;
            end
            ggem_pkg::ST_RUN_P0: begin
                n_p0        = w_c0_rdata;
                n_scan_prev = w_c0_rdata;
                n_i         = w_step;
                n_j         = w_step;
                if (r_step == '0 || ggem_pkg::t_coord'(w_step + w_step) >= w_rows
                        || ggem_pkg::t_coord'(w_step + w_step) >= w_cols) begin
                    n_state = ggem_pkg::ST_DONE;
                end else begin
                    n_state = ggem_pkg::ST_SAMPLE;
                end
            end
            ggem_pkg::ST_SAMPLE: begin
                n_state = ggem_pkg::ST_COMPARE;
            end
            ggem_pkg::ST_COMPARE: begin
                n_hit_scan  = ggem_pkg::f_absdiff(w_c0_rdata, r_scan_prev) > r_thr;
                n_hit_col   = ggem_pkg::f_absdiff(w_c0_rdata, w_colp) > r_thr;
                n_scan_prev = w_c0_rdata;
                n_state     = ggem_pkg::ST_SETUP;
            end
            ggem_pkg::ST_SETUP: begin
                if (r_hit_scan) begin
                    // mark left of the sample, step rows tall
                    n_hit_scan = 1'b0;
                    n_r        = r_i;
                    n_r_end    = ggem_pkg::f_min(w_i_next, w_rows);
                    n_c        = ggem_pkg::t_coord'(r_j - w_step);
                    n_c0       = ggem_pkg::t_coord'(r_j - w_step);
                    n_c_end    = ggem_pkg::f_min(
                        ggem_pkg::t_coord'(r_j - w_step + ggem_pkg::MARK_WIDTH), w_cols);
                    n_state    = ggem_pkg::ST_PAINT;
                end else if (r_hit_col) begin
                    // mark above the sample, step columns wide
                    n_hit_col = 1'b0;
                    n_r       = ggem_pkg::t_coord'(r_i - w_step);
                    n_r_end   = ggem_pkg::f_min(
                        ggem_pkg::t_coord'(r_i - w_step + ggem_pkg::MARK_WIDTH), w_rows);
                    n_c       = r_j;
                    n_c0      = r_j;
                    n_c_end   = ggem_pkg::f_min(w_j_next, w_cols);
                    n_state   = ggem_pkg::ST_PAINT;
                end else if (ggem_pkg::t_coord'(w_j_next + w_step) < w_cols) begin
                    n_j     = w_j_next;
                    n_state = ggem_pkg::ST_SAMPLE;
                end else if (ggem_pkg::t_coord'(w_i_next + w_step) < w_rows) begin
                    n_i     = w_i_next;
                    n_j     = w_step;
                    n_state = ggem_pkg::ST_SAMPLE;
                end else begin
                    n_state = ggem_pkg::ST_DONE;
                end
            end
            ggem_pkg::ST_PAINT: begin
                if (ggem_pkg::t_coord'(r_c + 1'b1) < r_c_end) begin
                    n_c = ggem_pkg::t_coord'(r_c + 1'b1);
                end else if (ggem_pkg::t_coord'(r_r + 1'b1) < r_r_end) begin
                    n_r = ggem_pkg::t_coord'(r_r + 1'b1);
                    n_c = r_c0;
                end else begin
                    n_state = ggem_pkg::ST_SETUP;
                end
            end
            ggem_pkg::ST_DONE: begin
                n_out_valid = 1'b1;
                n_out_c0    = '0;
                n_out_c1    = '0;
                n_out_c2    = '0;
                n_state     = ggem_pkg::ST_IDLE;
            end
            default: begin
                n_state = ggem_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ggem_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_hit_scan  <= 1'b0;
            r_hit_col   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_hit_scan  <= n_hit_scan;
            r_hit_col   <= n_hit_col;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i         <= n_i;
        r_j         <= n_j;
        r_r         <= n_r;
        r_c         <= n_c;
        r_c0        <= n_c0;
        r_r_end     <= n_r_end;
        r_c_end     <= n_c_end;
        r_scan_prev <= n_scan_prev;
        r_p0        <= n_p0;
        r_rd_inside <= n_rd_inside;
        r_out_c0    <= n_out_c0;
        r_out_c1    <= n_out_c1;
        r_out_c2    <= n_out_c2;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= ggem_pkg::THRESH_RESET;
            r_step     <= ggem_pkg::STEP_RESET;
            r_rows_cfg <= ggem_pkg::SIZE_RESET;
            r_cols_cfg <= ggem_pkg::SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (ggem_pkg::t_cfg_idx'(i_cfg_idx))
                ggem_pkg::CFG_THRESH: r_thr      <= i_cfg_data[PW-1:0];
                ggem_pkg::CFG_STEP:   r_step     <= i_cfg_data[ggem_pkg::STEP_W-1:0];
                ggem_pkg::CFG_ROWS:   r_rows_cfg <= i_cfg_data[ggem_pkg::SIZE_W-1:0];
                ggem_pkg::CFG_COLS:   r_cols_cfg <= i_cfg_data[ggem_pkg::SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// File: sim/grid_gradient_edge_marker_tb.sv
`timescale 1ns / 100ps

module grid_gradient_edge_marker_tb;

    localparam logic [ggem_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int FRAME_PIXELS = ggem_pkg::MAX_ROWS * ggem_pkg::MAX_COLS;
    localparam int TARGET_CMDS  = 1770;

    typedef struct packed {
        logic [ggem_pkg::KIND_W-1:0] kind;
        logic [7:0]                  row;
        logic [7:0]                  col;
        logic [7:0]                  c0;
        logic [7:0]                  c1;
        logic [7:0]                  c2;
    } t_pixel_cmd;

    typedef struct packed {
        logic [7:0] c2;
        logic [7:0] c1;
        logic [7:0] c0;
    } t_pixel_val;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            cfg_we;
    logic [ggem_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [ggem_pkg::CFG_DATA_W-1:0] cfg_data;

    ggem_in_if  in_bus ();
    ggem_out_if out_bus ();

    grid_gradient_edge_marker u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_bus),
        .o_out      (out_bus)
    );

    // predictor state
    logic [23:0] frame_model [0:FRAME_PIXELS-1];
    logic [7:0]  col_hist [0:ggem_pkg::MAX_COLS-1];
    logic [7:0]  scan_hist;
    logic [7:0]  cfg_thresh;
    logic [7:0]  cfg_step;
    logic [8:0]  cfg_rows;
    logic [8:0]  cfg_cols;

    // stimulus bookkeeping
    bit         pix_written [0:FRAME_PIXELS-1];
    int         written_addrs [$];
    t_pixel_cmd pending_cmds [$];
    t_pixel_val expected_pixels [$];

    int cmds_queued;
    int results_seen;
    int error_count;
    int idle_mode;
    int level_base;
    int level_spread;
    bit in_accepted;
    int send_gap;
    int send_burst;
    int hold_left;
    int take_left;

    always #5 i_clk = ~i_clk;

    function automatic int level_gap(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? int'(a - b) : int'(b - a);
    endfunction

    function automatic int eff_rows();
        return (cfg_rows > 9'(ggem_pkg::MAX_ROWS)) ? ggem_pkg::MAX_ROWS : int'(cfg_rows);
    endfunction

    function automatic int eff_cols();
        return (cfg_cols > 9'(ggem_pkg::MAX_COLS)) ? ggem_pkg::MAX_COLS : int'(cfg_cols);
    endfunction

    task automatic paint_mark(input int r0, input int rn, input int c0, input int cn,
                              input int rows, input int cols);
        for (int r = r0; r < r0 + rn && r < rows; r++) begin
            for (int c = c0; c < c0 + cn && c < cols; c++) begin
                frame_model[r * ggem_pkg::MAX_COLS + c][23:8] =
                    {ggem_pkg::MARK_CHAN2, ggem_pkg::MARK_CHAN1};
            end
        end
    endtask

    task automatic mark_pass();
        int rows;
        int cols;
        int s;
        logic [7:0] v;
        logic [7:0] p0;
        rows = eff_rows();
        cols = eff_cols();
        s = int'(cfg_step);
        p0 = frame_model[0][7:0];
        scan_hist = p0;
        for (int k = 0; k < ggem_pkg::MAX_COLS; k++) col_hist[k] = p0;
        if (s == 0) return;
        for (int i = s; i < rows - s; i += s) begin
            for (int j = s; j < cols - s; j += s) begin
                v = frame_model[i * ggem_pkg::MAX_COLS + j][7:0];
                if (level_gap(v, scan_hist) > int'(cfg_thresh))
                    paint_mark(i, s, j - s, ggem_pkg::MARK_WIDTH, rows, cols);
                scan_hist = v;
                if (level_gap(v, col_hist[j]) > int'(cfg_thresh))
                    paint_mark(i - s, ggem_pkg::MARK_WIDTH, j, s, rows, cols);
                col_hist[j] = v;
            end
        end
    endtask

    task automatic apply_cmd(input t_pixel_cmd cmd);
        t_pixel_val res;
        int a;
        res = '0;
        a = int'(cmd.row) * ggem_pkg::MAX_COLS + int'(cmd.col);
        case (cmd.kind)
            ggem_pkg::KIND_WRITE: frame_model[a] = {cmd.c2, cmd.c1, cmd.c0};
            ggem_pkg::KIND_RUN:   mark_pass();
            ggem_pkg::KIND_READ:  res = frame_model[a];
            default:              ;
        endcase
        expected_pixels.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // accept items into the predictor, check results against it
    always @(posedge i_clk) begin
        t_pixel_cmd cmd;
        t_pixel_val want;
        in_accepted = i_rst_n && in_bus.valid && in_bus.ready;
        if (in_accepted) begin
            cmd = {in_bus.kind, in_bus.row, in_bus.col,
                   in_bus.in_chan0, in_bus.in_chan1, in_bus.in_chan2};
            apply_cmd(cmd);
        end
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            results_seen++;
            if (expected_pixels.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual %0d %0d %0d",
                         $time, out_bus.out_chan0, out_bus.out_chan1,
                         out_bus.out_chan2);
                error_count++;
            end else begin
                want = expected_pixels.pop_front();
                check_field("out_chan0", want.c0, out_bus.out_chan0);
                check_field("out_chan1", want.c1, out_bus.out_chan1);
                check_field("out_chan2", want.c2, out_bus.out_chan2);
            end
        end
    end

    // item driver, bursts with random gaps
    always @(negedge i_clk) begin
        t_pixel_cmd cmd;
        if (i_rst_n && (!in_bus.valid || in_accepted)) begin
            if (send_gap > 0) begin
                send_gap--;
                in_bus.valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                cmd = pending_cmds.pop_front();
                in_bus.kind     <= cmd.kind;
                in_bus.row      <= cmd.row;
                in_bus.col      <= cmd.col;
                in_bus.in_chan0 <= cmd.c0;
                in_bus.in_chan1 <= cmd.c1;
                in_bus.in_chan2 <= cmd.c2;
                in_bus.valid    <= 1'b1;
                send_burst--;
                if (send_burst <= 0) begin
                    send_burst = $urandom_range(1, 24);
                    case (idle_mode)
                        0:       send_gap = 0;
                        1:       send_gap = $urandom_range(0, 2);
                        default: send_gap = $urandom_range(1, 15);
                    endcase
                end
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // result receiver stall pattern
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= 1'b1;
            if (take_left > 0) begin
                take_left--;
            end else begin
                take_left = $urandom_range(0, 20);
                case (idle_mode)
                    0:       hold_left = 0;
                    1:       hold_left = $urandom_range(0, 3);
                    default: hold_left = $urandom_range(1, 12);
                endcase
            end
        end
    end

    task automatic write_reg(input ggem_pkg::t_cfg_idx idx,
                             input logic [ggem_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            ggem_pkg::CFG_THRESH: cfg_thresh = val[7:0];
            ggem_pkg::CFG_STEP:   cfg_step   = val[7:0];
            ggem_pkg::CFG_ROWS:   cfg_rows   = val;
            ggem_pkg::CFG_COLS:   cfg_cols   = val;
            default:              ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (results_seen != cmds_queued) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_level();
        int v;
        if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
        v = int'($urandom_range(0, 2 * level_spread)) - level_spread + level_base;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    function automatic int pick_written_in(input int rows, input int cols);
        int a;
        for (int k = 0; k < 8; k++) begin
            a = int'($urandom_range(0, rows - 1)) * ggem_pkg::MAX_COLS
                + int'($urandom_range(0, cols - 1));
            if (pix_written[a]) return a;
        end
        return written_addrs[$urandom_range(0, written_addrs.size() - 1)];
    endfunction

    task automatic push_cmd(input logic [ggem_pkg::KIND_W-1:0] kind, input int r,
                            input int c, input int v0, input int v1, input int v2);
        t_pixel_cmd cmd;
        cmd = {kind, 8'(r), 8'(c), 8'(v0), 8'(v1), 8'(v2)};
        pending_cmds.push_back(cmd);
        cmds_queued++;
    endtask

    task automatic queue_write(input int r, input int c, input int v0, input int v1,
                               input int v2);
        int a;
        a = r * ggem_pkg::MAX_COLS + c;
        push_cmd(ggem_pkg::KIND_WRITE, r, c, v0, v1, v2);
        if (!pix_written[a]) begin
            pix_written[a] = 1'b1;
            written_addrs.push_back(a);
        end
    endtask

    task automatic queue_level_write(input int r, input int c);
        queue_write(r, c, pick_level(), $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    task automatic queue_read(input int a);
        push_cmd(ggem_pkg::KIND_READ, a / ggem_pkg::MAX_COLS, a % ggem_pkg::MAX_COLS,
                 $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    // every sample the pass compares must hold a written pixel
    task automatic queue_run();
        int rows;
        int cols;
        int s;
        rows = eff_rows();
        cols = eff_cols();
        s = int'(cfg_step);
        if (!pix_written[0]) queue_level_write(0, 0);
        if (s > 0) begin
            for (int i = s; i < rows - s; i += s) begin
                for (int j = s; j < cols - s; j += s) begin
                    if (!pix_written[i * ggem_pkg::MAX_COLS + j]) queue_level_write(i, j);
                end
            end
        end
        push_cmd(ggem_pkg::KIND_RUN, $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    task automatic random_op(input int rows, input int cols);
        int op;
        op = $urandom_range(0, 19);
        if (op <= 7) begin
            if ($urandom_range(0, 7) == 0)
                queue_level_write($urandom_range(0, 255), $urandom_range(0, 255));
            else
                queue_level_write($urandom_range(0, rows - 1), $urandom_range(0, cols - 1));
        end else if (op <= 16) begin
            queue_read(pick_written_in(rows, cols));
        end else if (op == 17) begin
            queue_run();
        end else if (op == 18) begin
            push_cmd(KIND_SPARE, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255));
        end else begin
            queue_write($urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255));
        end
    endtask

    task automatic random_phase();
        int th;
        int st;
        int nr;
        int nc;
        int rows;
        int cols;
        idle_mode = $urandom_range(0, 2);
        case ($urandom_range(0, 7))
            0:       th = 0;
            1:       th = 255;
            2:       th = $urandom_range(0, 255);
            default: th = $urandom_range(0, 40);
        endcase
        if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 4))
                0:       st = 64;
                1:       st = 85;
                2:       st = 100;
                3:       st = 128;
                default: st = $urandom_range(129, 255);
            endcase
            nr = ($urandom_range(0, 1) == 0) ? 256 : $urandom_range(200, 511);
            nc = ($urandom_range(0, 1) == 0) ? 256 : $urandom_range(200, 511);
        end else begin
            st = $urandom_range(1, 6);
            nr = $urandom_range(1, st * 8 + 2);
            nc = $urandom_range(1, st * 8 + 2);
            case ($urandom_range(0, 11))
                0:       st = 0;
                1:       nr = 0;
                2:       nc = 0;
                3:       nr = 1;
                default: ;
            endcase
        end
        write_reg(ggem_pkg::CFG_THRESH, {1'($urandom_range(0, 1)), 8'(th)});
        write_reg(ggem_pkg::CFG_STEP, {1'($urandom_range(0, 1)), 8'(st)});
        write_reg(ggem_pkg::CFG_ROWS, 9'(nr));
        write_reg(ggem_pkg::CFG_COLS, 9'(nc));
        level_base = $urandom_range(0, 255);
        level_spread = $urandom_range(2, 40);
        rows = (eff_rows() > 0) ? eff_rows() : 1;
        cols = (eff_cols() > 0) ? eff_cols() : 1;
        repeat ($urandom_range(10, 40)) random_op(rows, cols);
        queue_run();
        repeat ($urandom_range(10, 50)) random_op(rows, cols);
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        in_bus.valid = 1'b0;
        in_bus.kind = '0;
        in_bus.row = '0;
        in_bus.col = '0;
        in_bus.in_chan0 = '0;
        in_bus.in_chan1 = '0;
        in_bus.in_chan2 = '0;
        out_bus.ready = 1'b0;
        cfg_thresh = ggem_pkg::THRESH_RESET;
        cfg_step = ggem_pkg::STEP_RESET;
        cfg_rows = ggem_pkg::SIZE_RESET;
        cfg_cols = ggem_pkg::SIZE_RESET;
        scan_hist = '0;
        for (int k = 0; k < ggem_pkg::MAX_COLS; k++) col_hist[k] = '0;
        cmds_queued = 0;
        results_seen = 0;
        error_count = 0;
        idle_mode = 1;
        level_base = 128;
        level_spread = 20;
        in_accepted = 1'b0;
        send_gap = 0;
        send_burst = 8;
        hold_left = 0;
        take_left = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // corners of the address space and the spare kind
        queue_write(255, 255, 8'hff, 8'hff, 8'hff);
        queue_read(255 * ggem_pkg::MAX_COLS + 255);
        queue_write(0, 0, 8'h00, 8'h00, 8'h00);
        queue_read(0);
        push_cmd(KIND_SPARE, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
        queue_write(0, 0, 100, 8'h5a, 8'ha5);
        wait_idle();

        // difference equal to threshold, scan history carried across rows
        write_reg(ggem_pkg::CFG_THRESH, 9'h114);
        write_reg(ggem_pkg::CFG_STEP, 9'd4);
        write_reg(ggem_pkg::CFG_ROWS, 9'd13);
        write_reg(ggem_pkg::CFG_COLS, 9'd13);
        queue_write(4, 4, 120, 8'h11, 8'h22);
        queue_write(4, 8, 141, 8'h33, 8'h44);
        queue_write(8, 4, 141, 8'h55, 8'h66);
        queue_write(8, 8, 141, 8'h77, 8'h88);
        queue_write(5, 5, 7, 8'h01, 8'h02);
        queue_run();
        queue_read(4 * ggem_pkg::MAX_COLS + 4);
        queue_read(4 * ggem_pkg::MAX_COLS + 8);
        queue_read(8 * ggem_pkg::MAX_COLS + 4);
        queue_read(8 * ggem_pkg::MAX_COLS + 8);
        queue_read(5 * ggem_pkg::MAX_COLS + 5);
        queue_read(0);
        wait_idle();

        // zero step, then sizes beyond memory with the widest step
        write_reg(ggem_pkg::CFG_STEP, 9'd0);
        queue_run();
        queue_read(4 * ggem_pkg::MAX_COLS + 8);
        wait_idle();
        write_reg(ggem_pkg::CFG_STEP, 9'h1ff);
        write_reg(ggem_pkg::CFG_ROWS, 9'h1ff);
        write_reg(ggem_pkg::CFG_COLS, 9'd300);
        queue_run();
        queue_read(5 * ggem_pkg::MAX_COLS + 5);

        while (cmds_queued < TARGET_CMDS) begin
            wait_idle();
            random_phase();
        end

        wait_idle();
        repeat (20) @(negedge i_clk);
        if (error_count == 0 && expected_pixels.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            if (expected_pixels.size() != 0)
                $display("%0t ns: %0d results missing", $time, expected_pixels.size());
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("%0t ns: timeout", $time);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
